### design/dcrm_pkg.sv
`default_nettype none

package dcrm_pkg;

    // value and count widths
    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // input transfer: two ends of the range, either order
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] bound_a;
        logic [VALUE_WIDTH-1:0] bound_b;
    } t_in;

    // output transfer: best divisor count and smallest number having it
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] max_count;
        logic [VALUE_WIDTH-1:0] best_number;
    } t_out;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM_INIT,
        S_TEST,
        S_DIV,
        S_NUM_DONE,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture bounds, clear best
        logic num_init;  // start trial division of the current number
        logic div_start; // launch remainder of number by trial divisor
        logic accum;     // add divisor pair, step trial divisor
        logic num_done;  // compare count against best
        logic next_num;  // step to the next number
        logic out_load;  // move result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic sq_gt_n;   // trial divisor squared exceeds number
        logic div_done;  // remainder ready
        logic last_num;  // current number is the upper bound
        logic out_full;  // output register holds a result
    } t_dp_sts;

endpackage

`default_nettype wire

### design/dcrm_div.sv
`default_nettype none

// Restoring remainder unit, one quotient bit per cycle.
module dcrm_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [dcrm_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [dcrm_pkg::VALUE_WIDTH-1:0] i_divisor,
    output logic                                  o_done,
    output logic                                  o_rem_zero
);
    localparam int W  = dcrm_pkg::VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_d;
    logic [W:0]    n_trial;
    logic [W:0]    n_diff;
    logic [W-1:0]  n_rem;

    // one restoring step
    always_comb begin
        n_trial = {r_rem, r_dvd[W-1]};
        n_diff  = n_trial - {1'b0, r_d};
        if (n_trial >= {1'b0, r_d}) begin
            n_rem = n_diff[W-1:0];
        end else begin
            n_rem = n_trial[W-1:0];
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

### design/dcrm_dp.sv
`default_nettype none

// Datapath: range bounds, trial divisor and its square, counts, best, output register.
module dcrm_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dcrm_pkg::t_in     i_in_data,
    input  wire logic              i_out_stall,
    input  wire dcrm_pkg::t_dp_cmd i_cmd,
    output dcrm_pkg::t_dp_sts      o_sts,
    output logic                   o_out_valid,
    output dcrm_pkg::t_out         o_out_data
);
    localparam int W  = dcrm_pkg::VALUE_WIDTH;
    localparam int CW = dcrm_pkg::COUNT_WIDTH;

    logic [W-1:0]  n_a;
    logic [W-1:0]  n_b;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_hi;
    logic [W-1:0]  r_i;
    logic [W+1:0]  r_sq;
    logic [CW-1:0] r_cnt;
    logic [CW:0]   n_sum;
    logic [CW-1:0] r_best_cnt;
    logic [W-1:0]  r_best_num;
    logic          r_out_valid;
    dcrm_pkg::t_out r_out;
    logic          div_done;
    logic          rem_zero;

    // a zero bound counts as one
    always_comb begin
        n_a = (i_in_data.bound_a == '0) ? W'(1) : i_in_data.bound_a;
        n_b = (i_in_data.bound_b == '0) ? W'(1) : i_in_data.bound_b;
    end

    // saturating count update: a square root counts once, a pair twice
    always_comb begin
        n_sum = {1'b0, r_cnt} + ((r_sq == {2'b00, r_num}) ? (CW+1)'(1) : (CW+1)'(2));
    end

    dcrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num),
        .i_divisor  (r_i),
        .o_done     (div_done),
        .o_rem_zero (rem_zero)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num      <= (n_a > n_b) ? n_b : n_a;
            r_hi       <= (n_a > n_b) ? n_a : n_b;
            r_best_cnt <= '0;
        end
        if (i_cmd.num_init) begin
            r_i   <= W'(1);
            r_sq  <= (W+2)'(1);
            r_cnt <= '0;
        end
        if (i_cmd.accum) begin
            if (rem_zero) begin
                r_cnt <= n_sum[CW] ? dcrm_pkg::COUNT_MAX : n_sum[CW-1:0];
            end
            r_i  <= r_i + W'(1);
            r_sq <= r_sq + ({2'b00, r_i} << 1) + (W+2)'(1);
        end
        if (i_cmd.num_done && (r_cnt > r_best_cnt)) begin
            r_best_cnt <= r_cnt;
            r_best_num <= r_num;
        end
        if (i_cmd.next_num) begin
            r_num <= r_num + W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.max_count   <= r_best_cnt;
            r_out.best_number <= r_best_num;
        end
    end

    always_comb begin
        o_sts.sq_gt_n  = (r_sq > {2'b00, r_num});
        o_sts.div_done = div_done;
        o_sts.last_num = (r_num == r_hi);
        o_sts.out_full = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### design/dcrm_ctrl.sv
`default_nettype none

// Controller: walks the range, and trial divisors up to the square root of each number.
module dcrm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_stall,
    input  wire dcrm_pkg::t_dp_sts i_sts,
    output logic                   o_in_stall,
    output dcrm_pkg::t_dp_cmd      o_cmd
);
    dcrm_pkg::t_state r_state;
    dcrm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            dcrm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dcrm_pkg::S_NUM_INIT;
                end
            end
            dcrm_pkg::S_NUM_INIT: begin
                o_cmd.num_init = 1'b1;
                n_state        = dcrm_pkg::S_TEST;
            end
            dcrm_pkg::S_TEST: begin
                if (i_sts.sq_gt_n) begin
                    n_state = dcrm_pkg::S_NUM_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = dcrm_pkg::S_DIV;
                end
            end
            dcrm_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.accum = 1'b1;
                    n_state     = dcrm_pkg::S_TEST;
                end
            end
            dcrm_pkg::S_NUM_DONE: begin
                o_cmd.num_done = 1'b1;
                if (i_sts.last_num) begin
                    n_state = dcrm_pkg::S_FINISH;
                end else begin
                    o_cmd.next_num = 1'b1;
                    n_state        = dcrm_pkg::S_NUM_INIT;
                end
            end
            dcrm_pkg::S_FINISH: begin
                // wait for room in the output register
                if (!i_sts.out_full || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dcrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcrm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/divisor_count_range_max_top.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (bound_a, bound_b)
// out     | output    | o_out_valid / i_out_stall | o_out_data (max_count, best_number)
//
// One range at a time. For each number n in the range, the remainder unit
// runs once for each trial divisor up to floor(sqrt(n)), taking one
// quotient bit per cycle.
// Reset is synchronous, active low, and clears control state only.
// A result waiting under out stall holds; the next range is accepted meanwhile.
`default_nettype none

module divisor_count_range_max_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire dcrm_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output dcrm_pkg::t_out      o_out_data
);
    dcrm_pkg::t_dp_cmd cmd;
    dcrm_pkg::t_dp_sts sts;

    dcrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    dcrm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### design/dcrm_chk.sv
`default_nettype none

// Port-level checks for the divisor count block.
module dcrm_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire dcrm_pkg::t_out o_out_data
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // every number has at least one divisor
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.max_count != '0))
        else $error("zero divisor count");

    // the best number is never zero
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.best_number != '0))
        else $error("zero best number");

    // an open input stays open until a transfer arrives
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !i_in_valid |=> !o_in_stall)
        else $error("input closed without a transfer");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state after reset");

endmodule

bind divisor_count_range_max_top dcrm_chk u_dcrm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
